// ===== design/gbbm_pkg.sv =====
// ----------------------------------------------------------------------------
// gbbm_pkg
// Shared types, register indexes and helpers for the gaussian blur unit.
// ----------------------------------------------------------------------------
package gbbm_pkg;

    // input beat: push a pixel or drain one pending result
    typedef struct packed {
        logic       action;
        logic [7:0] pixel_in;
    } in_item_t;

    // output beat
    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_end;
    } out_item_t;

    // action codes
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // border modes
    localparam logic [1:0] MODE_ZERO   = 2'd0;
    localparam logic [1:0] MODE_MIRROR = 2'd1;
    localparam logic [1:0] MODE_RENORM = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_BORDER_MODE = 3'd0;
    localparam logic [2:0] CFG_RADIUS      = 3'd1;
    localparam logic [2:0] CFG_WIDTH       = 3'd2;
    localparam logic [2:0] CFG_HEIGHT      = 3'd3;
    localparam logic [2:0] CFG_ROW_W_LOW   = 3'd4;
    localparam logic [2:0] CFG_ROW_W_HIGH  = 3'd5;
    localparam logic [2:0] CFG_COL_W_LOW   = 3'd6;
    localparam logic [2:0] CFG_COL_W_HIGH  = 3'd7;

    // width of a signed kernel offset
    localparam int OFS_W = 4;

    // weight lane for a kernel offset, offsets beyond the lanes weigh zero
    function automatic logic [15:0] lane_pick(input logic [63:0] lo, input logic [47:0] hi,
                                              input logic signed [OFS_W-1:0] ofs);
        logic [15:0] v;
        begin
            case (ofs)
                -4'sd3:  v = lo[15:0];
                -4'sd2:  v = lo[31:16];
                -4'sd1:  v = lo[47:32];
                4'sd0:   v = lo[63:48];
                4'sd1:   v = hi[15:0];
                4'sd2:   v = hi[31:16];
                4'sd3:   v = hi[47:32];
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== design/gaussian_blur_border_modes_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_border_modes_unit
// Streaming separable gaussian blur over raster pixels held in a line memory.
// Each item passes S_NORM, S_MP, S_MQ and S_DEC. One that yields a result then
// reads all (2*radius+1)^2 taps in S_TAP, takes 8 divider steps in renormalize
// mode when the quotient is below 256, and waits in S_OUT while the output
// register stays stalled. Taps come from the single line memory read port, one tap a cycle.
// A finished result waits in the output register while the next beat is taken.
// Reset clears counters and control and loads the register defaults; the line
// memory is not cleared.
// ----------------------------------------------------------------------------
module gaussian_blur_border_modes_unit #(
    parameter int MAX_RADIUS  = 3,
    parameter int MAX_WIDTH   = 2048,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  gbbm_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output gbbm_pkg::out_item_t  out_data,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int SPAN   = 2 * MAX_RADIUS + 1;
    localparam int LB     = $clog2(2 * MAX_RADIUS + 2);
    localparam int CB     = $clog2(MAX_WIDTH);
    localparam int AW     = LB + CB;
    localparam int DEPTH  = 1 << AW;
    localparam int WPROD  = 2 * WEIGHT_BITS;
    localparam int TAPB   = $clog2(SPAN * SPAN);
    localparam int WS_W   = WPROD + TAPB;
    localparam int SUM_W  = WPROD + 8 + TAPB;
    localparam int SHIFT  = 2 * (WEIGHT_BITS - 1);
    localparam int OW     = gbbm_pkg::OFS_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_NORM = 8'b00000010,
        S_MP   = 8'b00000100,
        S_MQ   = 8'b00001000,
        S_DEC  = 8'b00010000,
        S_TAP  = 8'b00100000,
        S_DIV  = 8'b01000000,
        S_OUT  = 8'b10000000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [1:0]  radius_reg;
    logic [11:0] iw_reg;
    logic [12:0] ih_reg;
    logic [63:0] rwl_reg;
    logic [47:0] rwh_reg;
    logic [63:0] cwl_reg;
    logic [47:0] cwh_reg;

    // raster counters
    logic [12:0] in_row_reg;
    logic [11:0] in_col_reg;
    logic [12:0] out_row_reg;
    logic [11:0] out_col_reg;

    // per item work registers
    logic        act_reg;
    logic [7:0]  pix_reg;
    logic [24:0] n_reg;
    logic [24:0] p_reg;
    logic [24:0] q_reg;
    logic        fe_reg;
    logic [7:0]  res_reg;

    // tap sequencer and pipeline
    logic signed [OW-1:0] ta_reg;
    logic signed [OW-1:0] tb_reg;
    logic                 issue_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    logic [7:0]           rd_reg;
    logic [WPROD-1:0]     wt1_reg;
    logic                 use1_reg;
    logic                 in1_reg;
    logic [WPROD+7:0]     prod2_reg;
    logic [WPROD-1:0]     wt2_reg;
    logic                 in2_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [WS_W-1:0]      wsum_reg;

    // divider
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] dsh_reg;
    logic [7:0]       quo_reg;
    logic [2:0]       dcnt_reg;

    // output register
    logic                 out_valid_reg;
    gbbm_pkg::out_item_t  out_data_reg;

    // line memory
    logic [7:0] mem [DEPTH];

    // effective geometry
    logic [11:0] w;
    logic [12:0] h;
    logic [2:0]  rad;
    logic signed [OW-1:0] rad_s;

    always_comb
    begin
        if (iw_reg == 12'd0)
            w = 12'd1;
        else if (32'(iw_reg) > MAX_WIDTH)
            w = 12'(MAX_WIDTH);
        else
            w = iw_reg;
        h = (ih_reg == 13'd0) ? 13'd1 : ih_reg;
        rad = (32'(radius_reg) > MAX_RADIUS) ? 3'(MAX_RADIUS) : {1'b0, radius_reg};
        rad_s = signed'({1'b0, rad});
    end

    // normalized raster positions and the push step
    logic [12:0] pr, qr, pr_nx;
    logic [11:0] pc, qc, pc_nx;
    logic        push, p_lt, mem_we;

    always_comb
    begin
        if (in_row_reg >= h)
        begin
            pr = h;
            pc = 12'd0;
        end
        else if (in_col_reg >= w)
        begin
            pr = in_row_reg + 13'd1;
            pc = 12'd0;
        end
        else
        begin
            pr = in_row_reg;
            pc = in_col_reg;
        end
        if (out_row_reg >= h)
        begin
            qr = h;
            qc = 12'd0;
        end
        else if (out_col_reg >= w)
        begin
            qr = out_row_reg + 13'd1;
            qc = 12'd0;
        end
        else
        begin
            qr = out_row_reg;
            qc = out_col_reg;
        end
        // output past the frame end restarts the frame
        if (qr == h)
        begin
            qr = 13'd0;
            qc = 12'd0;
            pr = 13'd0;
            pc = 12'd0;
        end
        push = (act_reg == gbbm_pkg::ACT_PUSH);
        p_lt = (pr != h);
        mem_we = (state_reg == S_NORM) && push && p_lt;
        if (mem_we)
        begin
            if (pc + 12'd1 == w)
            begin
                pr_nx = pr + 13'd1;
                pc_nx = 12'd0;
            end
            else
            begin
                pr_nx = pr;
                pc_nx = pc + 12'd1;
            end
        end
        else
        begin
            pr_nx = pr;
            pc_nx = pc;
        end
    end

    // shared multiplier: row times width plus column
    logic [12:0] mul_a;
    logic [11:0] mul_add;
    logic [24:0] lin;
    logic [24:0] lead, need, nm1;
    logic        go;

    always_comb
    begin
        case (state_reg)
            S_NORM:
            begin
                mul_a = h;
                mul_add = 12'd0;
            end
            S_MP:
            begin
                mul_a = in_row_reg;
                mul_add = in_col_reg;
            end
            default:
            begin
                mul_a = out_row_reg;
                mul_add = out_col_reg;
            end
        endcase
        lin = 25'(mul_a) * 25'(w) + 25'(mul_add);
        lead = 25'(rad) * 25'(w) + 25'(rad);
        nm1 = n_reg - 25'd1;
        need = q_reg + lead;
        if (need > nm1)
            need = nm1;
        go = (p_reg == n_reg) || ((act_reg == gbbm_pkg::ACT_PUSH) && (p_reg > need));
    end

    // mirror an index back into the image
    function automatic logic signed [14:0] reflect(input logic signed [14:0] k,
                                                   input logic signed [14:0] size);
        logic signed [14:0] t;
        begin
            t = k;
            if (t < 15'sd0)
                t = -t;
            else if (t > size - 15'sd1)
                t = ((size - 15'sd1) <<< 1) - t;
            if (t < 15'sd0)
                t = 15'sd0;
            if (t > size - 15'sd1)
                t = size - 15'sd1;
            return t;
        end
    endfunction

    // tap address and weight
    logic signed [14:0] r_s, c_s, h_s, w_s, rr, cc, row_use, col_use;
    logic               in_img, use_pix;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [15:0]        rlane, clane;
    logic [WPROD-1:0]   wt0;
    logic [13:0]        pc_ext;

    always_comb
    begin
        h_s = signed'({2'b00, h});
        w_s = signed'({3'b000, w});
        r_s = signed'({2'b00, out_row_reg}) + {{(15-OW){ta_reg[OW-1]}}, ta_reg};
        c_s = signed'({3'b000, out_col_reg}) + {{(15-OW){tb_reg[OW-1]}}, tb_reg};
        in_img = (r_s >= 15'sd0) && (r_s < h_s) && (c_s >= 15'sd0) && (c_s < w_s);
        rr = reflect(r_s, h_s);
        cc = reflect(c_s, w_s);
        if (mode_reg == gbbm_pkg::MODE_MIRROR)
        begin
            row_use = rr;
            col_use = cc;
            use_pix = 1'b1;
        end
        else
        begin
            row_use = r_s;
            col_use = c_s;
            use_pix = in_img;
        end
        rd_addr = {row_use[LB-1:0], col_use[CB-1:0]};
        pc_ext = 14'(pc);
        wr_addr = {pr[LB-1:0], pc_ext[CB-1:0]};
        rlane = gbbm_pkg::lane_pick(rwl_reg, rwh_reg, ta_reg);
        clane = gbbm_pkg::lane_pick(cwl_reg, cwh_reg, tb_reg);
        wt0 = WPROD'(rlane[WEIGHT_BITS-1:0]) * WPROD'(clane[WEIGHT_BITS-1:0]);
    end

    // result of the shift path
    logic [7:0] shift_res;

    always_comb
    begin
        if (|sum_reg[SUM_W-1:SHIFT+8])
            shift_res = 8'hFF;
        else
            shift_res = sum_reg[SHIFT+7:SHIFT];
    end

    // divider step
    logic             dbit;
    logic [SUM_W-1:0] wsum8;

    always_comb
    begin
        dbit = (rem_reg >= dsh_reg);
        wsum8 = SUM_W'(wsum_reg) << 8;
    end

    // line memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= pix_reg;
        if (state_reg == S_TAP && issue_reg)
            rd_reg <= mem[rd_addr];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= gbbm_pkg::MODE_ZERO;
            radius_reg <= 2'd1;
            iw_reg     <= 12'd512;
            ih_reg     <= 13'd512;
            rwl_reg    <= 64'd4167838557550936064;
            rwh_reg    <= 48'd8982;
            cwl_reg    <= 64'd4167838557550936064;
            cwh_reg    <= 48'd8982;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gbbm_pkg::CFG_BORDER_MODE: mode_reg   <= cfg_data[1:0];
                gbbm_pkg::CFG_RADIUS:      radius_reg <= cfg_data[1:0];
                gbbm_pkg::CFG_WIDTH:       iw_reg     <= cfg_data[11:0];
                gbbm_pkg::CFG_HEIGHT:      ih_reg     <= cfg_data[12:0];
                gbbm_pkg::CFG_ROW_W_LOW:   rwl_reg    <= cfg_data;
                gbbm_pkg::CFG_ROW_W_HIGH:  rwh_reg    <= cfg_data[47:0];
                gbbm_pkg::CFG_COL_W_LOW:   cwl_reg    <= cfg_data;
                gbbm_pkg::CFG_COL_W_HIGH:  cwh_reg    <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // tap pipeline data, no reset needed
    always_ff @(posedge clk)
    begin
        wt1_reg   <= wt0;
        use1_reg  <= use_pix;
        in1_reg   <= in_img;
        prod2_reg <= (WPROD+8)'(wt1_reg) * (WPROD+8)'(use1_reg ? rd_reg : 8'd0);
        wt2_reg   <= wt1_reg;
        in2_reg   <= in1_reg;
        if (state_reg == S_IDLE && in_valid)
        begin
            act_reg <= in_data.action;
            pix_reg <= in_data.pixel_in;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_row_reg    <= 13'd0;
            in_col_reg    <= 12'd0;
            out_row_reg   <= 13'd0;
            out_col_reg   <= 12'd0;
            n_reg         <= 25'd0;
            p_reg         <= 25'd0;
            q_reg         <= 25'd0;
            fe_reg        <= 1'b0;
            res_reg       <= 8'd0;
            ta_reg        <= '0;
            tb_reg        <= '0;
            issue_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            sum_reg       <= '0;
            wsum_reg      <= '0;
            rem_reg       <= '0;
            dsh_reg       <= '0;
            quo_reg       <= 8'd0;
            dcnt_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // output register drains independently
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_NORM;
                end
                // store the pushed pixel and settle the counters
                S_NORM:
                begin
                    in_row_reg  <= pr_nx;
                    in_col_reg  <= pc_nx;
                    out_row_reg <= qr;
                    out_col_reg <= qc;
                    n_reg       <= lin;
                    state_reg   <= S_MP;
                end
                S_MP:
                begin
                    p_reg     <= lin;
                    state_reg <= S_MQ;
                end
                S_MQ:
                begin
                    q_reg     <= lin;
                    state_reg <= S_DEC;
                end
                // is the next output ready
                S_DEC:
                begin
                    fe_reg    <= (q_reg == nm1);
                    ta_reg    <= -rad_s;
                    tb_reg    <= -rad_s;
                    issue_reg <= 1'b1;
                    v1_reg    <= 1'b0;
                    v2_reg    <= 1'b0;
                    sum_reg   <= '0;
                    wsum_reg  <= '0;
                    state_reg <= go ? S_TAP : S_IDLE;
                end
                // walk the kernel taps, one memory read a cycle
                S_TAP:
                begin
                    v1_reg <= issue_reg;
                    v2_reg <= v1_reg;
                    if (issue_reg)
                    begin
                        if (tb_reg == rad_s)
                        begin
                            tb_reg <= -rad_s;
                            if (ta_reg == rad_s)
                                issue_reg <= 1'b0;
                            else
                                ta_reg <= ta_reg + OW'(1);
                        end
                        else
                            tb_reg <= tb_reg + OW'(1);
                    end
                    if (v2_reg)
                    begin
                        sum_reg  <= sum_reg + SUM_W'(prod2_reg);
                        wsum_reg <= wsum_reg + (in2_reg ? WS_W'(wt2_reg) : WS_W'(0));
                    end
                    if (!issue_reg && !v1_reg && !v2_reg)
                    begin
                        if (mode_reg == gbbm_pkg::MODE_RENORM)
                        begin
                            if (wsum_reg == '0)
                            begin
                                res_reg   <= 8'd0;
                                state_reg <= S_OUT;
                            end
                            else if (sum_reg >= wsum8)
                            begin
                                res_reg   <= 8'hFF;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                rem_reg   <= sum_reg;
                                dsh_reg   <= SUM_W'(wsum_reg) << 7;
                                quo_reg   <= 8'd0;
                                dcnt_reg  <= 3'd7;
                                state_reg <= S_DIV;
                            end
                        end
                        else
                        begin
                            res_reg   <= shift_res;
                            state_reg <= S_OUT;
                        end
                    end
                end
                // restoring division, one quotient bit a cycle
                S_DIV:
                begin
                    if (dbit)
                        rem_reg <= rem_reg - dsh_reg;
                    dsh_reg  <= dsh_reg >> 1;
                    quo_reg  <= {quo_reg[6:0], dbit};
                    dcnt_reg <= dcnt_reg - 3'd1;
                    if (dcnt_reg == 3'd0)
                    begin
                        res_reg   <= {quo_reg[6:0], dbit};
                        state_reg <= S_OUT;
                    end
                end
                // hand the beat over and advance the output position
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_data_reg.pixel_out <= res_reg;
                        out_data_reg.frame_end <= fe_reg;
                        if (q_reg + 25'd1 >= n_reg)
                        begin
                            in_row_reg  <= 13'd0;
                            in_col_reg  <= 12'd0;
                            out_row_reg <= 13'd0;
                            out_col_reg <= 12'd0;
                        end
                        else if (out_col_reg + 12'd1 == w)
                        begin
                            out_row_reg <= out_row_reg + 13'd1;
                            out_col_reg <= 12'd0;
                        end
                        else
                            out_col_reg <= out_col_reg + 12'd1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/gbbm_checker.sv =====
// ----------------------------------------------------------------------------
// gbbm_checker
// Port level checks for the gaussian blur unit, bound to the top level.
// ----------------------------------------------------------------------------
module gbbm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input gbbm_pkg::out_item_t out_data
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // one item at a time: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in work");

    // no result appears the cycle after an input beat
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

    // a taken result beat is not repeated without new work
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !in_stall |=> !out_valid)
        else $error("result beat repeated");

endmodule

bind gaussian_blur_border_modes_unit gbbm_checker u_gbbm_checker (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gaussian blur unit. A directed table with an
// identity kernel comes first, then random frames over many border modes,
// radii, geometries and weight sets. Every result beat is checked against a
// bit-accurate blur predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_COUNT  = 8;
    localparam int LINE_LEN    = 2048;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_WAIT  = 120;
    localparam int ITEM_COUNT  = 1000;
    localparam logic [63:0] DEF_W_LOW  = 64'd4167838557550936064;
    localparam logic [47:0] DEF_W_HIGH = 48'd8982;

    typedef struct {
        logic       action;
        logic [7:0] pixel;
        bit         typed;
        logic [7:0] exp_pixel;
        logic       exp_end;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    gbbm_pkg::in_item_t   in_data;
    logic                 out_valid;
    logic                 out_stall;
    gbbm_pkg::out_item_t  out_data;
    logic                 cfg_wr_en;
    logic [2:0]           cfg_index;
    logic [63:0]          cfg_data;

    // predictor copy of configuration and frame state
    logic [1:0]  bm_mode;
    logic [1:0]  bm_radius;
    logic [11:0] bm_width;
    logic [12:0] bm_height;
    logic [63:0] bm_row_lo;
    logic [47:0] bm_row_hi;
    logic [63:0] bm_col_lo;
    logic [47:0] bm_col_hi;
    logic [7:0]  line_mem [LINE_COUNT*LINE_LEN];
    int unsigned pos_in_row, pos_in_col, pos_out_row, pos_out_col;
    bit          frame_done;

    gbbm_pkg::out_item_t pending_pixels[$];
    int          mismatches;
    int          cycles;
    int          items_sent;
    bit          no_idle;
    bit          hold_req;
    dir_row_t    dir_tab[18];

    gaussian_blur_border_modes_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // weight lane of a kernel offset
    function automatic logic [15:0] tap_weight(input logic [63:0] lo, input logic [47:0] hi,
                                               input int ofs);
        if (ofs <= 0)
            return lo[16*(ofs+3) +: 16];
        return hi[16*(ofs-1) +: 16];
    endfunction

    // reflect-101 once, then clamp into the image
    function automatic int mirror_idx(input int k, input int size);
        int m;
        m = k;
        if (m < 0)
            m = -m;
        else if (m > size - 1)
            m = 2 * (size - 1) - m;
        if (m < 0)
            m = 0;
        if (m > size - 1)
            m = size - 1;
        return m;
    endfunction

    // weighted neighborhood sum at one output position
    function automatic logic [7:0] blur_at(input int qr, input int qc, input int w, input int h);
        int          rad;
        int          r, c, rr, cc;
        bit          in_img;
        longint unsigned sum, wsum, wt, res;
        logic [7:0]  pix;
        rad = bm_radius;
        sum = 0;
        wsum = 0;
        for (int a = -rad; a <= rad; a++)
        begin
            for (int b = -rad; b <= rad; b++)
            begin
                r = qr + a;
                c = qc + b;
                in_img = (r >= 0) && (r < h) && (c >= 0) && (c < w);
                wt = longint'(tap_weight(bm_row_lo, bm_row_hi, a)) *
                     longint'(tap_weight(bm_col_lo, bm_col_hi, b));
                pix = 8'd0;
                if (bm_mode == gbbm_pkg::MODE_MIRROR)
                begin
                    rr = mirror_idx(r, h);
                    cc = mirror_idx(c, w);
                    pix = line_mem[(rr % LINE_COUNT) * LINE_LEN + cc];
                end
                else if (in_img)
                    pix = line_mem[(r % LINE_COUNT) * LINE_LEN + c];
                sum += wt * pix;
                if (in_img)
                    wsum += wt;
            end
        end
        if (bm_mode == gbbm_pkg::MODE_RENORM)
            res = (wsum == 0) ? 0 : sum / wsum;
        else
            res = sum >> 30;
        return (res > 255) ? 8'd255 : res[7:0];
    endfunction

    // advance the frame state by one input beat
    task automatic blur_predict(input gbbm_pkg::in_item_t it, output bit has,
                                output gbbm_pkg::out_item_t res);
        int unsigned w, h, n, d, p, q, need;
        bit          push;
        w = (bm_width < 1) ? 1 : ((bm_width > LINE_LEN) ? LINE_LEN : bm_width);
        h = (bm_height < 1) ? 1 : bm_height;
        n = w * h;
        d = bm_radius * w + bm_radius;
        push = (it.action == gbbm_pkg::ACT_PUSH);
        has = 1'b0;
        res = '0;
        p = (pos_in_row >= h) ? n : pos_in_row * w + ((pos_in_col < w) ? pos_in_col : w);
        if (p > n)
            p = n;
        q = (pos_out_row >= h) ? n : pos_out_row * w + ((pos_out_col < w) ? pos_out_col : w);
        if (q >= n)
        begin
            q = 0;
            p = 0;
        end
        if (push && p < n)
        begin
            line_mem[((p / w) % LINE_COUNT) * LINE_LEN + (p % w)] = it.pixel_in;
            p++;
        end
        pos_in_row = (p >= n) ? h : p / w;
        pos_in_col = (p >= n) ? 0 : p % w;
        pos_out_row = q / w;
        pos_out_col = q % w;
        need = q + d;
        if (need > n - 1)
            need = n - 1;
        if (p == n || (push && p >= need + 1))
        begin
            has = 1'b1;
            res.pixel_out = blur_at(q / w, q % w, w, h);
            res.frame_end = (q == n - 1);
            q++;
            if (q >= n)
            begin
                pos_in_row = 0;
                pos_in_col = 0;
                pos_out_row = 0;
                pos_out_col = 0;
                frame_done = 1'b1;
            end
            else
            begin
                pos_out_row = q / w;
                pos_out_col = q % w;
            end
        end
    endtask

    // predict, queue the expectation and drive one input beat
    task automatic send_beat(input gbbm_pkg::in_item_t it, input bit typed,
                             input gbbm_pkg::out_item_t typed_val);
        bit                  has;
        gbbm_pkg::out_item_t res;
        int                  gap;
        blur_predict(it, has, res);
        if (has)
            pending_pixels.push_back(typed ? typed_val : res);
        gap = no_idle ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = it;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_plain(input logic act, input logic [7:0] pix);
        gbbm_pkg::in_item_t it;
        it.action = act;
        it.pixel_in = pix;
        send_beat(it, 1'b0, '0);
    endtask

    // wait until every result is in and the block has gone quiet
    task automatic wait_idle();
        in_valid = 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            gbbm_pkg::CFG_BORDER_MODE: bm_mode = val[1:0];
            gbbm_pkg::CFG_RADIUS:      bm_radius = val[1:0];
            gbbm_pkg::CFG_WIDTH:       bm_width = val[11:0];
            gbbm_pkg::CFG_HEIGHT:      bm_height = val[12:0];
            gbbm_pkg::CFG_ROW_W_LOW:   bm_row_lo = val;
            gbbm_pkg::CFG_ROW_W_HIGH:  bm_row_hi = val[47:0];
            gbbm_pkg::CFG_COL_W_LOW:   bm_col_lo = val;
            default:                   bm_col_hi = val[47:0];
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic setup(input logic [1:0] mode, input logic [1:0] rad, input logic [11:0] w,
                         input logic [12:0] h, input logic [63:0] rlo, input logic [47:0] rhi,
                         input logic [63:0] clo, input logic [47:0] chi);
        wait_idle();
        cfg_write(gbbm_pkg::CFG_BORDER_MODE, {62'd0, mode});
        cfg_write(gbbm_pkg::CFG_RADIUS, {62'd0, rad});
        cfg_write(gbbm_pkg::CFG_WIDTH, {52'd0, w});
        cfg_write(gbbm_pkg::CFG_HEIGHT, {51'd0, h});
        cfg_write(gbbm_pkg::CFG_ROW_W_LOW, rlo);
        cfg_write(gbbm_pkg::CFG_ROW_W_HIGH, {16'd0, rhi});
        cfg_write(gbbm_pkg::CFG_COL_W_LOW, clo);
        cfg_write(gbbm_pkg::CFG_COL_W_HIGH, {16'd0, chi});
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // one whole frame: pushes with stray drains, then mixed pushes and drains until frame end
    task automatic run_frame();
        int unsigned w, h;
        w = (bm_width < 1) ? 1 : ((bm_width > LINE_LEN) ? LINE_LEN : bm_width);
        h = (bm_height < 1) ? 1 : bm_height;
        frame_done = 1'b0;
        for (int i = 0; i < w * h; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_plain(gbbm_pkg::ACT_DRAIN, 8'($urandom));
            send_plain(gbbm_pkg::ACT_PUSH, rand_pixel());
        end
        while (!frame_done)
            send_plain(($urandom_range(0, 2) == 0) ? gbbm_pkg::ACT_PUSH : gbbm_pkg::ACT_DRAIN,
                       rand_pixel());
        // drain with nothing pending
        if ($urandom_range(0, 3) == 0)
            send_plain(gbbm_pkg::ACT_DRAIN, 8'($urandom));
    endtask

    // random weight set of one direction
    task automatic pick_weights(output logic [63:0] lo, output logic [47:0] hi);
        case ($urandom_range(0, 4))
            0:
            begin
                lo = DEF_W_LOW;
                hi = DEF_W_HIGH;
            end
            1:
            begin
                lo = {$urandom, $urandom};
                hi = {16'($urandom), $urandom};
            end
            2:
            begin
                lo = '1;
                hi = '1;
            end
            3:
            begin
                lo = {16'h8000, {3{4'h0, 12'($urandom)}}};
                hi = {3{4'h0, 12'($urandom)}};
            end
            default:
            begin
                lo = '0;
                hi = '0;
            end
        endcase
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, out_data);
                mismatches++;
            end
            else
            begin
                gbbm_pkg::out_item_t want;
                want = pending_pixels.pop_front();
                if (want.pixel_out !== out_data.pixel_out)
                begin
                    $display("%0t: pixel_out expected %h actual %h", $time,
                             want.pixel_out, out_data.pixel_out);
                    mismatches++;
                end
                if (want.frame_end !== out_data.frame_end)
                begin
                    $display("%0t: frame_end expected %b actual %b", $time,
                             want.frame_end, out_data.frame_end);
                    mismatches++;
                end
            end
        end
    end

    // receiver stalls, with one long hold-off on request
    initial
    begin
        int k;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            k = no_idle ? 0 : $urandom_range(0, 10);
            if (hold_req)
            begin
                k = 400;
                hold_req = 1'b0;
            end
            out_stall = (k > 0);
            repeat (k) @(negedge clk);
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // stimulus
    initial
    begin
        logic [63:0]         rlo, clo;
        logic [47:0]         rhi, chi;
        gbbm_pkg::in_item_t  it;
        gbbm_pkg::out_item_t tv;
        int                  frames;
        cycles = 0;
        mismatches = 0;
        items_sent = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = gbbm_pkg::CFG_BORDER_MODE;
        cfg_data = '0;
        bm_mode = gbbm_pkg::MODE_ZERO;
        bm_radius = 2'd1;
        bm_width = 12'd512;
        bm_height = 13'd512;
        bm_row_lo = DEF_W_LOW;
        bm_row_hi = DEF_W_HIGH;
        bm_col_lo = DEF_W_LOW;
        bm_col_hi = DEF_W_HIGH;
        pos_in_row = 0;
        pos_in_col = 0;
        pos_out_row = 0;
        pos_out_col = 0;
        foreach (line_mem[i])
            line_mem[i] = 8'd0;
        // identity kernel, each push returns its own pixel
        dir_tab = '{
            '{gbbm_pkg::ACT_DRAIN, 8'h00, 1'b0, 8'h00, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'h00, 1'b1, 8'h00, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'hFF, 1'b1, 8'hFF, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'h01, 1'b1, 8'h01, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'h80, 1'b1, 8'h80, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'h7F, 1'b1, 8'h7F, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'hFE, 1'b1, 8'hFE, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'h55, 1'b1, 8'h55, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'hAA, 1'b1, 8'hAA, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'h0F, 1'b1, 8'h0F, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'hF0, 1'b1, 8'hF0, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'h33, 1'b1, 8'h33, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'hCC, 1'b1, 8'hCC, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'h00, 1'b1, 8'h00, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'hFF, 1'b1, 8'hFF, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'h02, 1'b1, 8'h02, 1'b0},
            '{gbbm_pkg::ACT_PUSH,  8'h40, 1'b1, 8'h40, 1'b1},
            '{gbbm_pkg::ACT_DRAIN, 8'hFF, 1'b0, 8'h00, 1'b0}
        };
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        setup(gbbm_pkg::MODE_ZERO, 2'd0, 12'd4, 13'd4, {16'h8000, 48'd0}, 48'd0,
              {16'h8000, 48'd0}, 48'd0);
        foreach (dir_tab[i])
        begin
            it.action = dir_tab[i].action;
            it.pixel_in = dir_tab[i].pixel;
            tv.pixel_out = dir_tab[i].exp_pixel;
            tv.frame_end = dir_tab[i].exp_end;
            send_beat(it, dir_tab[i].typed, tv);
        end

        // corner geometries
        setup(gbbm_pkg::MODE_MIRROR, 2'd3, 12'd4, 13'd4, DEF_W_LOW, DEF_W_HIGH, '1, '1);
        run_frame();
        setup(gbbm_pkg::MODE_RENORM, 2'd3, 12'd4, 13'd4, DEF_W_LOW, DEF_W_HIGH,
              DEF_W_LOW, DEF_W_HIGH);
        run_frame();
        setup(gbbm_pkg::MODE_RENORM, 2'd2, 12'd5, 13'd4, '0, '0, '0, '0);
        run_frame();
        setup(gbbm_pkg::MODE_MIRROR, 2'd3, 12'd0, 13'd0, DEF_W_LOW, DEF_W_HIGH,
              DEF_W_LOW, DEF_W_HIGH);
        run_frame();
        setup(2'd3, 2'd3, 12'd1, 13'd6, DEF_W_LOW, DEF_W_HIGH, DEF_W_LOW, DEF_W_HIGH);
        run_frame();
        no_idle = 1'b1;
        setup(gbbm_pkg::MODE_ZERO, 2'd3, 12'd8, 13'd5, DEF_W_LOW, DEF_W_HIGH,
              DEF_W_LOW, DEF_W_HIGH);
        hold_req = 1'b1;
        run_frame();
        no_idle = 1'b0;

        // random phases
        while (items_sent < ITEM_COUNT)
        begin
            pick_weights(rlo, rhi);
            pick_weights(clo, chi);
            setup(2'($urandom), 2'($urandom), 12'($urandom_range(4, 12)),
                  13'($urandom_range(4, 8)), rlo, rhi, clo, chi);
            no_idle = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 2);
            repeat (frames) run_frame();
        end

        in_valid = 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
